/* rtl/vfjb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and sizes for the voice frame jitter buffer.
// Used by every module of the block except vfjb_ram; depends on nothing else.
package vfjb_pkg;

  // Queue and frame sizing
  localparam int QUEUE_DEPTH       = 32;
  localparam int FRAME_WIDTH       = 64;
  localparam int FRAMES_PER_PACKET = 5;

  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W       = 6;
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LEFT_W      = $clog2(FRAMES_PER_PACKET + 1);
  localparam int FRAME_BYTES = (FRAME_WIDTH + 7) / 8;

  // Packet header checks
  localparam int HDR_BYTES   = 14;
  localparam int MAX_LEN     = HDR_BYTES + FRAME_BYTES * FRAMES_PER_PACKET;
  localparam logic [7:0] MAGIC_A     = 8'h57;
  localparam logic [7:0] MAGIC_B     = 8'h54;
  localparam logic [7:0] FMT_VERSION = 8'd2;
  localparam logic [15:0] STALE_SPAN = 16'h8000;
  localparam logic [2:0] IDLE_STOP   = 3'd3;
  localparam logic [2:0] IDLE_MAX    = 3'd7;
  localparam logic [7:0] UNDERRUN_MAX = 8'd255;
  localparam logic [1:0] GOOD_MAX    = 2'd3;

  // Configuration reset values and port sizing
  localparam int CFG_ADDR_W = 4;
  localparam logic [31:0] OWN_NODE_RESET  = 32'd1;
  localparam logic [CFG_W-1:0] MIN_PRE_RESET   = 6'd10;
  localparam logic [CFG_W-1:0] MAX_PRE_RESET   = 6'd15;
  localparam logic [CFG_W-1:0] QUEUE_LIM_RESET = 6'd25;

  typedef enum logic [1:0] {
    REG_OWN_NODE  = 2'd0,
    REG_MIN_PRE   = 2'd1,
    REG_MAX_PRE   = 2'd2,
    REG_QUEUE_LIM = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    REQ_HEADER = 3'd0,
    REQ_FRAME  = 3'd1,
    REQ_PLAY   = 3'd2,
    REQ_WINDOW = 3'd3,
    REQ_FLUSH  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_GAP      = 3'd1,
    STS_STALE    = 3'd2,
    STS_BAD      = 3'd3,
    STS_OWN      = 3'd4,
    STS_OVERFLOW = 3'd5,
    STS_IGNORED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PK_NONE    = 2'd0,
    PK_SILENCE = 2'd1,
    PK_FRAME   = 2'd2,
    PK_CONCEAL = 2'd3
  } play_t;

  // Input request payload, last member in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [63:0] frame_bits;
    logic [15:0] first_frame_index;
    logic [15:0] session_tag;
    logic [31:0] source_id;
    logic [7:0]  format_version;
    logic [7:0]  magic_second;
    logic [7:0]  magic_first;
    logic [7:0]  packet_len;
    logic        read_ok;
  } in_item_t;

  // Result payload, last member in the lowest bits
  typedef struct packed {
    logic              playing;
    logic [CFG_W-1:0]  prebuffer_target;
    logic [CFG_W-1:0]  frames_held;
    logic [63:0]       frame_out;
    logic [2:0]        status;
  } out_item_t;

  localparam int IN_DATA_W  = $bits(in_item_t);
  localparam int OUT_DATA_W = $bits(out_item_t);

  typedef struct packed {
    logic [31:0]      own_node_id;
    logic [CFG_W-1:0] min_prebuffer;
    logic [CFG_W-1:0] max_prebuffer;
    logic [CFG_W-1:0] queue_limit;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

/* rtl/vfjb_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module vfjb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/vfjb_ctrl.sv */
`timescale 1ns / 1ps
// Request sequencer: takes one request, then runs it once the result slot is free.
// Depends on vfjb_pkg for command and status types.
module vfjb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_tready,
  input  vfjb_pkg::dp_status_t dp_status,
  output vfjb_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   slot_free;

  // Result slot is free when empty or drained this cycle
  assign slot_free = !dp_status.out_valid || out_tready;

  assign in_tready   = (state_r == ST_IDLE);
  assign cmd.capture = in_tvalid && (state_r == ST_IDLE);
  assign cmd.execute = (state_r == ST_EXEC) && slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A request is never taken while one is still pending
  a_no_capture_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !cmd.capture)
    else $error("request taken while another is pending");

  // Every captured request is executed right after or held pending
  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC))
    else $error("captured request lost");

  // A stalled request runs as soon as the result slot drains
  a_exec_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && !dp_status.out_valid) |-> cmd.execute)
    else $error("request stalled with a free result slot");

endmodule

/* rtl/vfjb_dpath.sv */
`timescale 1ns / 1ps
// Jitter buffer datapath: request register, stream and playout state,
// frame queue memory and result register. Depends on vfjb_pkg and vfjb_ram.
module vfjb_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vfjb_pkg::cmd_t        cmd,
  output vfjb_pkg::dp_status_t  dp_status,
  input  vfjb_pkg::cfg_t        cfg,
  input  logic [vfjb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]                      in_tuser,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [vfjb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser
);

  localparam int PTR_W  = vfjb_pkg::PTR_W;
  localparam int CNT_W  = vfjb_pkg::CNT_W;
  localparam int CFG_W  = vfjb_pkg::CFG_W;
  localparam int CMP_W  = vfjb_pkg::CMP_W;
  localparam int LEFT_W = vfjb_pkg::LEFT_W;
  localparam int FW     = vfjb_pkg::FRAME_WIDTH;

  // Pending request
  vfjb_pkg::in_item_t item_r;
  logic [2:0]         req_r;

  // Queue and stream state
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              active_r, active_nxt;
  logic [CFG_W-1:0]  target_r, target_nxt;
  logic [7:0]        underrun_r, underrun_nxt;
  logic [1:0]        good_r, good_nxt;
  logic [31:0]       src_r, src_nxt;
  logic [15:0]       ses_r, ses_nxt;
  logic [15:0]       exp_r, exp_nxt;
  logic              accepting_r, accepting_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [2:0]        idle_r, idle_nxt;

  // Result slot
  logic                out_valid_r;
  vfjb_pkg::out_item_t out_data_r;
  logic [1:0]          out_kind_r;

  // Request evaluation
  logic                  hdr_bad;
  logic                  hdr_keep;
  logic [15:0]           idx_diff;
  logic [7:0]            len_body;
  logic [LEFT_W-1:0]     hdr_frames;
  logic [CMP_W-1:0]      lim;
  logic                  queue_full;
  logic                  play_start;
  logic [2:0]            idle_sat;
  logic [1:0]            good_sat;
  logic                  ram_we;
  logic [FW-1:0]         ram_rdata;
  vfjb_pkg::status_t     status_c;
  vfjb_pkg::play_t       kind_c;
  logic [63:0]           frame_c;

  // Frame queue storage
  vfjb_ram #(
    .WIDTH(FW),
    .DEPTH(vfjb_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(item_r.frame_bits[FW-1:0]),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  // Hold the request until it runs
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= vfjb_pkg::in_item_t'(in_tdata);
      req_r  <= in_tuser;
    end
  end

  // Header checks
  assign hdr_bad = !item_r.read_ok ||
                   (item_r.packet_len <= 8'(vfjb_pkg::HDR_BYTES)) ||
                   (item_r.packet_len > 8'(vfjb_pkg::MAX_LEN)) ||
                   (item_r.magic_first != vfjb_pkg::MAGIC_A) ||
                   (item_r.magic_second != vfjb_pkg::MAGIC_B) ||
                   (item_r.format_version != vfjb_pkg::FMT_VERSION);
  assign idx_diff   = item_r.first_frame_index - exp_r;
  assign len_body   = item_r.packet_len - 8'(vfjb_pkg::HDR_BYTES);
  assign hdr_frames = LEFT_W'(len_body / vfjb_pkg::FRAME_BYTES);

  // Queue limit capped at the queue depth
  assign lim = (CMP_W'(cfg.queue_limit) > CMP_W'(vfjb_pkg::QUEUE_DEPTH)) ?
               CMP_W'(vfjb_pkg::QUEUE_DEPTH) : CMP_W'(cfg.queue_limit);
  assign queue_full = CMP_W'(held_r) >= lim;

  // Playout start and saturating counters
  assign play_start = !active_r && (CMP_W'(held_r) >= CMP_W'(target_r));
  assign idle_sat   = (idle_r != vfjb_pkg::IDLE_MAX) ? idle_r + 3'd1 : idle_r;
  assign good_sat   = (good_r != vfjb_pkg::GOOD_MAX) ? good_r + 2'd1 : good_r;

  // Run the pending request
  always_comb begin
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    active_nxt    = active_r;
    target_nxt    = target_r;
    underrun_nxt  = underrun_r;
    good_nxt      = good_r;
    src_nxt       = src_r;
    ses_nxt       = ses_r;
    exp_nxt       = exp_r;
    accepting_nxt = accepting_r;
    left_nxt      = left_r;
    idle_nxt      = idle_r;
    hdr_keep      = 1'b0;
    ram_we        = 1'b0;
    status_c      = vfjb_pkg::STS_OK;
    kind_c        = vfjb_pkg::PK_NONE;
    frame_c       = '0;
    unique case (req_r)
      vfjb_pkg::REQ_HEADER: begin
        accepting_nxt = 1'b0;
        left_nxt      = '0;
        if (hdr_bad) begin
          status_c = vfjb_pkg::STS_BAD;
        end else if (item_r.source_id == cfg.own_node_id) begin
          status_c = vfjb_pkg::STS_OWN;
        end else if (item_r.source_id != src_r || item_r.session_tag != ses_r) begin
          // New stream: restart playout and empty the queue
          src_nxt      = item_r.source_id;
          ses_nxt      = item_r.session_tag;
          rp_nxt       = '0;
          wp_nxt       = '0;
          held_nxt     = '0;
          active_nxt   = 1'b0;
          target_nxt   = cfg.min_prebuffer;
          underrun_nxt = '0;
          good_nxt     = '0;
          idle_nxt     = '0;
          hdr_keep     = 1'b1;
        end else if (idx_diff > vfjb_pkg::STALE_SPAN) begin
          status_c = vfjb_pkg::STS_STALE;
        end else begin
          hdr_keep = 1'b1;
          if (idx_diff != 16'd0) begin
            status_c = vfjb_pkg::STS_GAP;
          end
        end
        if (hdr_keep) begin
          exp_nxt       = item_r.first_frame_index + 16'(vfjb_pkg::FRAMES_PER_PACKET);
          left_nxt      = hdr_frames;
          accepting_nxt = (hdr_frames != '0);
        end
      end
      vfjb_pkg::REQ_FRAME: begin
        if (!accepting_r || left_r == '0) begin
          status_c = vfjb_pkg::STS_IGNORED;
        end else begin
          left_nxt = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) begin
            accepting_nxt = 1'b0;
          end
          if (queue_full) begin
            status_c = vfjb_pkg::STS_OVERFLOW;
          end else begin
            // Push the frame
            ram_we   = 1'b1;
            wp_nxt   = (wp_r == PTR_W'(vfjb_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
            held_nxt = held_r + CNT_W'(1);
            idle_nxt = '0;
          end
        end
      end
      vfjb_pkg::REQ_PLAY: begin
        if (!(active_r || play_start)) begin
          idle_nxt = idle_sat;
          kind_c   = vfjb_pkg::PK_SILENCE;
        end else begin
          active_nxt = 1'b1;
          if (held_r != '0) begin
            // Pop the oldest frame
            frame_c  = 64'(ram_rdata);
            rp_nxt   = (rp_r == PTR_W'(vfjb_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
            held_nxt = held_r - CNT_W'(1);
            idle_nxt = '0;
            kind_c   = vfjb_pkg::PK_FRAME;
          end else begin
            // Underrun: conceal, and stop after enough idle ticks
            idle_nxt = idle_sat;
            if (idle_sat >= vfjb_pkg::IDLE_STOP) begin
              active_nxt = 1'b0;
            end
            if (underrun_r != vfjb_pkg::UNDERRUN_MAX) begin
              underrun_nxt = underrun_r + 8'd1;
            end
            kind_c = vfjb_pkg::PK_CONCEAL;
          end
        end
      end
      vfjb_pkg::REQ_WINDOW: begin
        if (underrun_r > 8'd1) begin
          target_nxt = cfg.max_prebuffer;
          good_nxt   = '0;
        end else if (underrun_r == 8'd0) begin
          good_nxt = good_sat;
          if (good_sat == vfjb_pkg::GOOD_MAX) begin
            target_nxt = cfg.min_prebuffer;
          end
        end else begin
          good_nxt = '0;
        end
        underrun_nxt = '0;
      end
      vfjb_pkg::REQ_FLUSH: begin
        rp_nxt        = '0;
        wp_nxt        = '0;
        held_nxt      = '0;
        active_nxt    = 1'b0;
        target_nxt    = cfg.min_prebuffer;
        underrun_nxt  = '0;
        good_nxt      = '0;
        idle_nxt      = '0;
        src_nxt       = '0;
        ses_nxt       = '0;
        exp_nxt       = '0;
        accepting_nxt = 1'b0;
        left_nxt      = '0;
      end
      default: begin
        status_c = vfjb_pkg::STS_IGNORED;
      end
    endcase
    if (!cmd.execute) begin
      ram_we = 1'b0;
    end
  end

  // Commit state when the request runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      active_r    <= 1'b0;
      target_r    <= vfjb_pkg::MIN_PRE_RESET;
      underrun_r  <= '0;
      good_r      <= '0;
      src_r       <= '0;
      ses_r       <= '0;
      exp_r       <= '0;
      accepting_r <= 1'b0;
      left_r      <= '0;
      idle_r      <= '0;
    end else if (cmd.execute) begin
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      active_r    <= active_nxt;
      target_r    <= target_nxt;
      underrun_r  <= underrun_nxt;
      good_r      <= good_nxt;
      src_r       <= src_nxt;
      ses_r       <= ses_nxt;
      exp_r       <= exp_nxt;
      accepting_r <= accepting_nxt;
      left_r      <= left_nxt;
      idle_r      <= idle_nxt;
    end
  end

  // Result slot: load on execute, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data_r.status           <= status_c;
      out_data_r.frame_out        <= frame_c;
      out_data_r.frames_held      <= CFG_W'(held_nxt);
      out_data_r.prebuffer_target <= target_nxt;
      out_data_r.playing          <= active_nxt;
      out_kind_r                  <= kind_c;
    end
  end

  assign out_tvalid          = out_valid_r;
  assign out_tdata           = out_data_r;
  assign out_tuser           = out_kind_r;
  assign dp_status.out_valid = out_valid_r;

  // Queue never holds more than its depth
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(held_r) <= CMP_W'(vfjb_pkg::QUEUE_DEPTH))
    else $error("frame count beyond queue depth");

  // Admission flag and pending frame count move together
  a_accept_left: assert property (@(posedge clk) disable iff (!rst_n)
    accepting_r == (left_r != '0))
    else $error("admission flag out of step with pending frames");

  // No push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CMP_W'(held_r) < CMP_W'(vfjb_pkg::QUEUE_DEPTH)))
    else $error("push into full queue");

  // A new result appears only after a request has run
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.execute))
    else $error("result without a request");

endmodule

/* rtl/voice_frame_jitter_buffer_core.sv */
`timescale 1ns / 1ps
// Top level of the voice frame jitter buffer: configuration registers and wiring
// of the sequencer and datapath. Depends on vfjb_pkg, vfjb_ctrl, vfjb_dpath.
//
//  Channel  Direction  Handshake                    Carries
//  in_      slave      in_tvalid / in_tready        tuser: req_type; tdata: header/frame
//  out_     master     out_tvalid / out_tready      tuser: play_kind; tdata: result
//  cfg_     APB slave  psel, penable, pwrite        four registers at 0x0..0xC (one 32-bit, three 6-bit)
//
// Each request is first captured into the request register, then run against the
// frame store, whose read data is registered and must settle on the read pointer.
// A finished result waits in an output register; the next request is captured
// meanwhile and runs as soon as that register drains.
// Reset is synchronous on rst_n; the frame store needs no clearing pass.
module voice_frame_jitter_buffer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // read_ok, packet_len, magic_first, magic_second, format_version, source_id,
  // session_tag, first_frame_index, frame_bits, zero pad (lowest bit first)
  input  logic [167:0] in_tdata,
  // req_type
  input  logic [2:0]   in_tuser,
  // Result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, frame_out, frames_held, prebuffer_target, playing (lowest bit first)
  output logic [79:0]  out_tdata,
  // play_kind
  output logic [1:0]   out_tuser,
  // Configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  vfjb_pkg::cfg_t       cfg_r;
  vfjb_pkg::cmd_t       cmd;
  vfjb_pkg::dp_status_t dp_status;
  logic                 cfg_wr;
  vfjb_pkg::cfg_reg_t   cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = vfjb_pkg::cfg_reg_t'(cfg_paddr[3:2]);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node_id   <= vfjb_pkg::OWN_NODE_RESET;
      cfg_r.min_prebuffer <= vfjb_pkg::MIN_PRE_RESET;
      cfg_r.max_prebuffer <= vfjb_pkg::MAX_PRE_RESET;
      cfg_r.queue_limit   <= vfjb_pkg::QUEUE_LIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        vfjb_pkg::REG_OWN_NODE:  cfg_r.own_node_id   <= cfg_pwdata;
        vfjb_pkg::REG_MIN_PRE:   cfg_r.min_prebuffer <= cfg_pwdata[vfjb_pkg::CFG_W-1:0];
        vfjb_pkg::REG_MAX_PRE:   cfg_r.max_prebuffer <= cfg_pwdata[vfjb_pkg::CFG_W-1:0];
        vfjb_pkg::REG_QUEUE_LIM: cfg_r.queue_limit   <= cfg_pwdata[vfjb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_sel)
      vfjb_pkg::REG_OWN_NODE:  cfg_prdata = cfg_r.own_node_id;
      vfjb_pkg::REG_MIN_PRE:   cfg_prdata = 32'(cfg_r.min_prebuffer);
      vfjb_pkg::REG_MAX_PRE:   cfg_prdata = 32'(cfg_r.max_prebuffer);
      vfjb_pkg::REG_QUEUE_LIM: cfg_prdata = 32'(cfg_r.queue_limit);
      default:                 cfg_prdata = '0;
    endcase
  end

  vfjb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tready(out_tready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  vfjb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .dp_status (dp_status),
    .cfg       (cfg_r),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
